@@ src/assert_macros.svh @@
// shared assertion macros for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define MEXP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mexp assertion failed");

// next-cycle implication, disabled during reset
`define MEXP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mexp assertion failed");

`endif

@@ src/mexp_pkg.sv @@
package mexp_pkg;

	localparam int FIELD_W = 64;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_REDUCE = 5'b00010,
		ST_LOAD   = 5'b00100,
		ST_MUL    = 5'b01000,
		ST_FIN    = 5'b10000
	} state_t;

endpackage

@@ src/modular_exponentiation_core.sv @@
// Computes base_value ** exponent mod modulus on the low WIDTH bits of each field; the
// upper result bits are zero, and a modulus of 0 or 1 gives 0. One request is worked
// at a time: the base is first reduced one dividend bit per cycle, then each of the
// WIDTH exponent bits is worked in a load step and a multiply loop, in which the square
// and the multiply share one doubling adder and walk their multipliers one bit per cycle.
// A modulus of 0 or 1 skips the reduction and the multiply loop and goes straight to the
// finish state. The result sits in an output register, so a new request is taken while
// the previous result waits to be taken.
module modular_exponentiation_core #(
	parameter int WIDTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [mexp_pkg::FIELD_W-1:0] base_value,
	input  logic [mexp_pkg::FIELD_W-1:0] exponent,
	input  logic [mexp_pkg::FIELD_W-1:0] modulus,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [mexp_pkg::FIELD_W-1:0] power_result
);

	localparam int FW = mexp_pkg::FIELD_W;
	localparam int CW = $clog2(WIDTH);
	localparam logic [CW-1:0] LAST = CW'(WIDTH - 1);

	mexp_pkg::state_t state_q;
	logic             out_valid_q;
	logic [WIDTH-1:0] pwr_q;

	logic [WIDTH-1:0] m_q, e_q, div_q, rem_q, b_q, r_q;
	logic [WIDTH-1:0] x_q, ysq_q, yr_q, acc_r_q, acc_b_q;
	logic [CW-1:0]    step_q, bit_q;

	logic             in_acc, out_free;
	logic [WIDTH-1:0] m_in;
	logic [WIDTH:0]   red_t, red_diff;
	logic [WIDTH-1:0] red_nx;
	logic [WIDTH-1:0] x_nx, acc_r_nx, acc_b_nx;

	// (a + b) mod m for a, b below m, with one extra sum bit
	function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] a,
		input logic [WIDTH-1:0] b, input logic [WIDTH-1:0] m);
		logic [WIDTH:0] s;
		logic [WIDTH:0] d;
		s = {1'b0, a} + {1'b0, b};
		d = s - {1'b0, m};
		if (s >= {1'b0, m}) begin
			add_mod = d[WIDTH-1:0];
		end else begin
			add_mod = s[WIDTH-1:0];
		end
	endfunction

	assign in_stall  = (state_q != mexp_pkg::ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign power_result = FW'(pwr_q);
	assign m_in      = modulus[WIDTH-1:0];

	// restoring remainder step for the base reduction
	assign red_t    = {rem_q, div_q[WIDTH-1]};
	assign red_diff = red_t - {1'b0, m_q};
	assign red_nx   = (red_t >= {1'b0, m_q}) ? red_diff[WIDTH-1:0] : red_t[WIDTH-1:0];

	// square and multiply share the doubled base; r * b is walked over the bits of r
	assign x_nx     = add_mod(x_q, x_q, m_q);
	assign acc_r_nx = yr_q[0]  ? add_mod(acc_r_q, x_q, m_q) : acc_r_q;
	assign acc_b_nx = ysq_q[0] ? add_mod(acc_b_q, x_q, m_q) : acc_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mexp_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == mexp_pkg::ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				mexp_pkg::ST_IDLE: begin
					if (in_acc) begin
						state_q <= (m_in <= WIDTH'(1)) ? mexp_pkg::ST_FIN
							: mexp_pkg::ST_REDUCE;
					end
				end
				mexp_pkg::ST_REDUCE: begin
					if (step_q == LAST) begin
						state_q <= mexp_pkg::ST_LOAD;
					end
				end
				mexp_pkg::ST_LOAD: begin
					state_q <= mexp_pkg::ST_MUL;
				end
				mexp_pkg::ST_MUL: begin
					if (step_q == LAST) begin
						state_q <= (bit_q == LAST) ? mexp_pkg::ST_FIN : mexp_pkg::ST_LOAD;
					end
				end
				mexp_pkg::ST_FIN: begin
					if (out_free) begin
						state_q <= mexp_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= mexp_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			mexp_pkg::ST_IDLE: begin
				if (in_acc) begin
					m_q    <= m_in;
					e_q    <= exponent[WIDTH-1:0];
					div_q  <= base_value[WIDTH-1:0];
					rem_q  <= '0;
					r_q    <= '0;
					step_q <= '0;
				end
			end
			mexp_pkg::ST_REDUCE: begin
				rem_q  <= red_nx;
				div_q  <= div_q << 1;
				step_q <= step_q + CW'(1);
				if (step_q == LAST) begin
					b_q   <= red_nx;
					r_q   <= WIDTH'(1);
					bit_q <= '0;
				end
			end
			mexp_pkg::ST_LOAD: begin
				x_q     <= b_q;
				ysq_q   <= b_q;
				yr_q    <= r_q;
				acc_r_q <= '0;
				acc_b_q <= '0;
				step_q  <= '0;
			end
			mexp_pkg::ST_MUL: begin
				x_q     <= x_nx;
				acc_r_q <= acc_r_nx;
				acc_b_q <= acc_b_nx;
				ysq_q   <= ysq_q >> 1;
				yr_q    <= yr_q >> 1;
				step_q  <= step_q + CW'(1);
				if (step_q == LAST) begin
					if (e_q[0]) begin
						r_q <= acc_r_nx;
					end
					b_q   <= acc_b_nx;
					e_q   <= e_q >> 1;
					bit_q <= bit_q + CW'(1);
				end
			end
			mexp_pkg::ST_FIN: begin
				if (out_free) begin
					pwr_q <= r_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

@@ src/mexp_checker.sv @@
`include "assert_macros.svh"

module mexp_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [mexp_pkg::FIELD_W-1:0] power_result
);

	logic       in_acc, out_acc;
	logic [1:0] pend_q;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// requests taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
		end else if (in_acc && !out_acc) begin
			pend_q <= pend_q + 2'd1;
		end else if (out_acc && !in_acc) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	`MEXP_ASSERT_IMP(a_no_spurious_result, clk, arst_n, out_valid, pend_q != 2'd0)
	`MEXP_ASSERT_IMP(a_at_most_two_pending, clk, arst_n, in_acc,
		pend_q != 2'd2 && pend_q != 2'd3)
	`MEXP_ASSERT_NXT(a_busy_after_request, clk, arst_n, in_acc, in_stall)
	`MEXP_ASSERT_NXT(a_result_holds, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(power_result))

endmodule

bind modular_exponentiation_core mexp_checker u_mexp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.power_result (power_result)
);
